### rtl/core/csrc_pkg.sv
// ----------------------------------------------------------------------------
// csrc_pkg
// Shared types and constants of the command servo ramp controller.
// ----------------------------------------------------------------------------
package csrc_pkg;

	// widths
	localparam int unsigned ANGLE_W = 8;
	localparam int unsigned PULSE_W = 12;
	localparam int unsigned DRIVE_W = 4;
	localparam int unsigned CMD_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_MIN     = 3'd0,
		CFG_BASE_MAX     = 3'd1,
		CFG_SHOULDER_MAX = 3'd2,
		CFG_ELBOW_MAX    = 3'd3,
		CFG_WRIST_MAX    = 3'd4,
		CFG_ELBOW_PRESET = 3'd5,
		CFG_WRIST_PRESET = 3'd6
	} cfg_idx_t;

	// configuration reset values
	localparam logic [ANGLE_W-1:0] RST_BASE_MIN     = 8'd5;
	localparam logic [ANGLE_W-1:0] RST_BASE_MAX     = 8'd40;
	localparam logic [ANGLE_W-1:0] RST_SHOULDER_MAX = 8'd180;
	localparam logic [ANGLE_W-1:0] RST_ELBOW_MAX    = 8'd120;
	localparam logic [ANGLE_W-1:0] RST_WRIST_MAX    = 8'd120;
	localparam logic [ANGLE_W-1:0] RST_ELBOW_PRESET = 8'd65;
	localparam logic [ANGLE_W-1:0] RST_WRIST_PRESET = 8'd110;

	// angle reset values
	localparam logic [ANGLE_W-1:0] RST_BASE_ANGLE     = 8'd5;
	localparam logic [ANGLE_W-1:0] RST_SHOULDER_ANGLE = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_ELBOW_ANGLE    = 8'd65;
	localparam logic [ANGLE_W-1:0] RST_WRIST_ANGLE    = 8'd110;

	// ramp modes
	typedef enum logic [3:0] {
		MODE_NONE          = 4'd0,
		MODE_BASE_UP       = 4'd1,
		MODE_BASE_DOWN     = 4'd2,
		MODE_SHOULDER_UP   = 4'd3,
		MODE_SHOULDER_DOWN = 4'd4,
		MODE_ELBOW_UP      = 4'd5,
		MODE_ELBOW_DOWN    = 4'd6,
		MODE_WRIST_UP      = 4'd7,
		MODE_WRIST_DOWN    = 4'd8
	} ramp_mode_t;

	// drive pin patterns
	localparam logic [DRIVE_W-1:0] DRIVE_A   = 4'd5;
	localparam logic [DRIVE_W-1:0] DRIVE_B   = 4'd9;
	localparam logic [DRIVE_W-1:0] DRIVE_C   = 4'd6;
	localparam logic [DRIVE_W-1:0] DRIVE_D   = 4'd10;
	localparam logic [DRIVE_W-1:0] DRIVE_OFF = 4'd0;

	// command characters
	localparam logic [CMD_W-1:0] CMD_A = 8'h41;
	localparam logic [CMD_W-1:0] CMD_B = 8'h42;
	localparam logic [CMD_W-1:0] CMD_C = 8'h43;
	localparam logic [CMD_W-1:0] CMD_D = 8'h44;
	localparam logic [CMD_W-1:0] CMD_E = 8'h45;
	localparam logic [CMD_W-1:0] CMD_F = 8'h46;
	localparam logic [CMD_W-1:0] CMD_G = 8'h47;
	localparam logic [CMD_W-1:0] CMD_H = 8'h48;
	localparam logic [CMD_W-1:0] CMD_I = 8'h49;
	localparam logic [CMD_W-1:0] CMD_J = 8'h4A;
	localparam logic [CMD_W-1:0] CMD_K = 8'h4B;
	localparam logic [CMD_W-1:0] CMD_L = 8'h4C;
	localparam logic [CMD_W-1:0] CMD_N = 8'h4E;
	localparam logic [CMD_W-1:0] CMD_O = 8'h4F;
	localparam logic [CMD_W-1:0] CMD_P = 8'h50;
	localparam logic [CMD_W-1:0] CMD_Q = 8'h51;
	localparam logic [CMD_W-1:0] CMD_X = 8'h58;

	// pulse = 125*(4a+180)/36 = 125*(a+45)/9
	// 125*ceil(2^19/9) as reciprocal, exact for every 8-bit angle
	localparam logic [8:0]  PULSE_OFFSET = 9'd45;
	localparam logic [31:0] PULSE_RECIP  = 32'd7281875;
	localparam int unsigned PULSE_SHIFT  = 19;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;

endpackage

### rtl/core/csrc_if.sv
// ----------------------------------------------------------------------------
// csrc interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: command byte or ramp tick
interface csrc_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [csrc_pkg::CMD_W-1:0]    cmd_byte;

	modport source (output valid, output req_type, output cmd_byte, input ready);
	modport sink   (input valid, input req_type, input cmd_byte, output ready);
endinterface

// result channel: pins and servo pulse widths
interface csrc_res_if;
	logic                          valid;
	logic                          ready;
	logic [csrc_pkg::DRIVE_W-1:0]  drive_pins;
	logic                          lamp_pin;
	logic                          aux_pin;
	logic [csrc_pkg::PULSE_W-1:0]  base_pulse;
	logic [csrc_pkg::PULSE_W-1:0]  shoulder_pulse;
	logic [csrc_pkg::PULSE_W-1:0]  elbow_pulse;
	logic [csrc_pkg::PULSE_W-1:0]  wrist_pulse;

	modport source (output valid, output drive_pins, output lamp_pin, output aux_pin,
		output base_pulse, output shoulder_pulse, output elbow_pulse,
		output wrist_pulse, input ready);
	modport sink   (input valid, input drive_pins, input lamp_pin, input aux_pin,
		input base_pulse, input shoulder_pulse, input elbow_pulse,
		input wrist_pulse, output ready);
endinterface

// configuration write channel
interface csrc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [csrc_pkg::CFG_IDX_W-1:0]  index;
	logic [csrc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/csrc_pulse.sv
// ----------------------------------------------------------------------------
// csrc_pulse
// Converts a servo angle to a PWM pulse width, saturated to twelve bits.
// ----------------------------------------------------------------------------
module csrc_pulse (
	input  logic [csrc_pkg::ANGLE_W-1:0] angle,
	output logic [csrc_pkg::PULSE_W-1:0] pulse
);

	logic [8:0]  offs;
	logic [31:0] prod;
	logic [12:0] quo;

	// divide by nine through a reciprocal multiply
	always_comb begin
		offs  = {1'b0, angle} + csrc_pkg::PULSE_OFFSET;
		prod  = 32'(offs) * csrc_pkg::PULSE_RECIP;
		quo   = prod[31:csrc_pkg::PULSE_SHIFT];
		pulse = (quo > 13'(csrc_pkg::PULSE_MAX)) ? csrc_pkg::PULSE_MAX
			: quo[csrc_pkg::PULSE_W-1:0];
	end

endmodule

### rtl/core/command_servo_ramp_controller.sv
// ----------------------------------------------------------------------------
// command_servo_ramp_controller
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register is reloaded in the
// same cycle it is taken, so a stall holds requests only while it is full.
// Reset: arst_n clears angles, pins and ramp mode to their power-on values
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module command_servo_ramp_controller (
	input  logic         clk,
	input  logic         arst_n,
	csrc_req_if.sink     req,
	csrc_res_if.source   res,
	csrc_cfg_if.sink     cfg
);

	localparam int unsigned AW = csrc_pkg::ANGLE_W;

	// configuration registers
	logic [AW-1:0] base_min_q, base_max_q, shoulder_max_q, elbow_max_q;
	logic [AW-1:0] wrist_max_q, elbow_preset_q, wrist_preset_q;

	// controller state
	csrc_pkg::ramp_mode_t             ramp_mode_q, ramp_mode_d;
	logic [AW-1:0]                    base_q, shoulder_q, elbow_q, wrist_q;
	logic [AW-1:0]                    base_d, shoulder_d, elbow_d, wrist_d;
	logic [csrc_pkg::DRIVE_W-1:0]     drive_q, drive_d;
	logic                             lamp_q, lamp_d, aux_q, aux_d;

	// result register
	logic                             res_valid_q;
	logic [csrc_pkg::PULSE_W-1:0]     base_pulse_d, shoulder_pulse_d;
	logic [csrc_pkg::PULSE_W-1:0]     elbow_pulse_d, wrist_pulse_d;

	logic req_acc;
	logic cfg_acc;

	// handshakes
	assign req.ready = !res_valid_q || res.ready;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_min_q     <= csrc_pkg::RST_BASE_MIN;
			base_max_q     <= csrc_pkg::RST_BASE_MAX;
			shoulder_max_q <= csrc_pkg::RST_SHOULDER_MAX;
			elbow_max_q    <= csrc_pkg::RST_ELBOW_MAX;
			wrist_max_q    <= csrc_pkg::RST_WRIST_MAX;
			elbow_preset_q <= csrc_pkg::RST_ELBOW_PRESET;
			wrist_preset_q <= csrc_pkg::RST_WRIST_PRESET;
		end else if (cfg_acc) begin
			case (cfg.index)
				csrc_pkg::CFG_BASE_MIN:     base_min_q     <= cfg.data;
				csrc_pkg::CFG_BASE_MAX:     base_max_q     <= cfg.data;
				csrc_pkg::CFG_SHOULDER_MAX: shoulder_max_q <= cfg.data;
				csrc_pkg::CFG_ELBOW_MAX:    elbow_max_q    <= cfg.data;
				csrc_pkg::CFG_WRIST_MAX:    wrist_max_q    <= cfg.data;
				csrc_pkg::CFG_ELBOW_PRESET: elbow_preset_q <= cfg.data;
				csrc_pkg::CFG_WRIST_PRESET: wrist_preset_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state from a tick or a command
	always_comb begin
		ramp_mode_d = ramp_mode_q;
		base_d      = base_q;
		shoulder_d  = shoulder_q;
		elbow_d     = elbow_q;
		wrist_d     = wrist_q;
		drive_d     = drive_q;
		lamp_d      = lamp_q;
		aux_d       = aux_q;
		if (req.req_type) begin
			case (ramp_mode_q)
				csrc_pkg::MODE_BASE_UP:
					if (base_q < base_max_q) base_d = base_q + 8'd1;
				csrc_pkg::MODE_BASE_DOWN:
					if (base_q > base_min_q) base_d = base_q - 8'd1;
				csrc_pkg::MODE_SHOULDER_UP:
					if (shoulder_q < shoulder_max_q) shoulder_d = shoulder_q + 8'd1;
				csrc_pkg::MODE_SHOULDER_DOWN:
					if (shoulder_q != '0) shoulder_d = shoulder_q - 8'd1;
				csrc_pkg::MODE_ELBOW_UP:
					if (elbow_q < elbow_max_q) elbow_d = elbow_q + 8'd1;
				csrc_pkg::MODE_ELBOW_DOWN:
					if (elbow_q != '0) elbow_d = elbow_q - 8'd1;
				csrc_pkg::MODE_WRIST_UP:
					if (wrist_q < wrist_max_q) wrist_d = wrist_q + 8'd1;
				csrc_pkg::MODE_WRIST_DOWN:
					if (wrist_q != '0) wrist_d = wrist_q - 8'd1;
				default: ;
			endcase
		end else begin
			case (req.cmd_byte)
				csrc_pkg::CMD_A: drive_d = csrc_pkg::DRIVE_A;
				csrc_pkg::CMD_B: drive_d = csrc_pkg::DRIVE_B;
				csrc_pkg::CMD_C: drive_d = csrc_pkg::DRIVE_C;
				csrc_pkg::CMD_D: drive_d = csrc_pkg::DRIVE_D;
				csrc_pkg::CMD_E: begin
					drive_d     = csrc_pkg::DRIVE_OFF;
					aux_d       = 1'b0;
					ramp_mode_d = csrc_pkg::MODE_NONE;
				end
				csrc_pkg::CMD_L: lamp_d = 1'b1;
				csrc_pkg::CMD_X: lamp_d = 1'b0;
				csrc_pkg::CMD_Q: aux_d  = 1'b1;
				csrc_pkg::CMD_F: ramp_mode_d = csrc_pkg::MODE_BASE_UP;
				csrc_pkg::CMD_G: ramp_mode_d = csrc_pkg::MODE_BASE_DOWN;
				csrc_pkg::CMD_H: ramp_mode_d = csrc_pkg::MODE_SHOULDER_UP;
				csrc_pkg::CMD_I: ramp_mode_d = csrc_pkg::MODE_SHOULDER_DOWN;
				csrc_pkg::CMD_J: ramp_mode_d = csrc_pkg::MODE_ELBOW_UP;
				csrc_pkg::CMD_K: ramp_mode_d = csrc_pkg::MODE_ELBOW_DOWN;
				csrc_pkg::CMD_N: ramp_mode_d = csrc_pkg::MODE_WRIST_UP;
				csrc_pkg::CMD_O: ramp_mode_d = csrc_pkg::MODE_WRIST_DOWN;
				csrc_pkg::CMD_P: begin
					elbow_d = elbow_preset_q;
					wrist_d = wrist_preset_q;
				end
				default: ;
			endcase
		end
	end

	// pulse widths from the updated angles
	csrc_pulse u_base_pulse     (.angle(base_d),     .pulse(base_pulse_d));
	csrc_pulse u_shoulder_pulse (.angle(shoulder_d), .pulse(shoulder_pulse_d));
	csrc_pulse u_elbow_pulse    (.angle(elbow_d),    .pulse(elbow_pulse_d));
	csrc_pulse u_wrist_pulse    (.angle(wrist_d),    .pulse(wrist_pulse_d));

	// state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_mode_q <= csrc_pkg::MODE_NONE;
			base_q      <= csrc_pkg::RST_BASE_ANGLE;
			shoulder_q  <= csrc_pkg::RST_SHOULDER_ANGLE;
			elbow_q     <= csrc_pkg::RST_ELBOW_ANGLE;
			wrist_q     <= csrc_pkg::RST_WRIST_ANGLE;
			drive_q     <= csrc_pkg::DRIVE_OFF;
			lamp_q      <= 1'b0;
			aux_q       <= 1'b0;
		end else if (req_acc) begin
			ramp_mode_q <= ramp_mode_d;
			base_q      <= base_d;
			shoulder_q  <= shoulder_d;
			elbow_q     <= elbow_d;
			wrist_q     <= wrist_d;
			drive_q     <= drive_d;
			lamp_q      <= lamp_d;
			aux_q       <= aux_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			res.drive_pins     <= drive_d;
			res.lamp_pin       <= lamp_d;
			res.aux_pin        <= aux_d;
			res.base_pulse     <= base_pulse_d;
			res.shoulder_pulse <= shoulder_pulse_d;
			res.elbow_pulse    <= elbow_pulse_d;
			res.wrist_pulse    <= wrist_pulse_d;
		end
	end

	assign res.valid = res_valid_q;

	// an accepted request always leaves a result behind
	a_req_gives_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> res_valid_q)
		else $error("accepted request left no result");

	// drive pattern only takes the command patterns
	a_drive_legal: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q == csrc_pkg::DRIVE_OFF || drive_q == csrc_pkg::DRIVE_A ||
		drive_q == csrc_pkg::DRIVE_B || drive_q == csrc_pkg::DRIVE_C ||
		drive_q == csrc_pkg::DRIVE_D)
		else $error("drive pattern out of set");

	// stop command clears the drive pattern, aux and ramp mode
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !req.req_type && req.cmd_byte == csrc_pkg::CMD_E) |=>
		(ramp_mode_q == csrc_pkg::MODE_NONE && !aux_q && drive_q == csrc_pkg::DRIVE_OFF))
		else $error("stop command did not clear state");

	// base ramps up by exactly one below its limit
	a_base_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.req_type && ramp_mode_q == csrc_pkg::MODE_BASE_UP &&
		base_q < base_max_q) |=> (base_q == $past(base_q) + 8'd1))
		else $error("base ramp step wrong");

	// angles hold without an accepted request
	a_angles_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req_acc |=> ($stable(base_q) && $stable(shoulder_q) &&
		$stable(elbow_q) && $stable(wrist_q)))
		else $error("angle moved without request");

endmodule
